@@ src/assert_macros.svh @@
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define BPFA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BPFA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/bpfa_pkg.sv @@
// shared types, codes and helpers for the bitmap page frame allocator
package bpfa_pkg;

    localparam int FRAME_COUNT_DEF = 4096;
    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int WORD_BITS       = 32;

    typedef logic [1:0]  opcode_t;
    typedef logic [1:0]  status_t;
    typedef logic [31:0] word_t;

    localparam word_t ALL_ONES = 32'hFFFF_FFFF;

    // operation codes
    localparam opcode_t OP_ALLOC   = 2'd0;
    localparam opcode_t OP_FREE    = 2'd1;
    localparam opcode_t OP_RELEASE = 2'd2;

    // result status codes
    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_NO_FRAME = 2'd1;
    localparam status_t STAT_IGNORED  = 2'd2;

    // index of the lowest clear bit of a bitmap word
    function automatic logic [4:0] lowest_zero(input word_t w);
        word_t      inv;
        word_t      onehot;
        logic [4:0] idx;
        inv    = ~w;
        onehot = inv & (~inv + 32'd1);
        idx    = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (onehot[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/bpfa_ram.sv @@
// generic simple dual port ram with registered read
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/bpfa_region.sv @@
// two stage unit that turns a region into a clipped range of frames
module bpfa_region #(
    parameter int FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BYTES  = bpfa_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [63:0] region_base,
    input  logic [63:0] region_length,
    input  logic [31:0] lowest_free_address,
    output logic        done,
    output logic        empty,
    output logic [((33 - $clog2(PAGE_BYTES)) > $clog2(FRAME_COUNT + 1) ?
                   (33 - $clog2(PAGE_BYTES)) : $clog2(FRAME_COUNT + 1))-1:0] lo_frame,
    output logic [((33 - $clog2(PAGE_BYTES)) > $clog2(FRAME_COUNT + 1) ?
                   (33 - $clog2(PAGE_BYTES)) : $clog2(FRAME_COUNT + 1))-1:0] hi_frame
);

    localparam int PS  = $clog2(PAGE_BYTES);
    localparam int LW  = 33 - PS;
    localparam int FSW = $clog2(FRAME_COUNT + 1);
    localparam int RW  = (LW > FSW) ? LW : FSW;

    // stage a: end clip and page rounding
    logic          a_valid_reg;
    logic          a_skip_reg;
    logic [31:0]   a_end_reg;
    logic [LW-1:0] a_lo_reg;
    logic [LW-1:0] a_floor_reg;

    logic [64:0]   sum;
    logic [32:0]   lo_ceil;
    logic [32:0]   floor_ceil;

    assign sum        = {1'b0, region_base} + {1'b0, region_length};
    assign lo_ceil    = {1'b0, region_base[31:0]} + 33'(PAGE_BYTES - 1);
    assign floor_ceil = {1'b0, lowest_free_address} + 33'(PAGE_BYTES - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= go;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            a_skip_reg  <= |region_base[63:32];
            a_end_reg   <= (|sum[64:32]) ? bpfa_pkg::ALL_ONES : sum[31:0];
            a_lo_reg    <= lo_ceil[32:PS];
            a_floor_reg <= floor_ceil[32:PS];
        end
    end

    // stage b: floor, capacity clamp and emptiness
    logic          done_reg;
    logic          empty_reg;
    logic [RW-1:0] lo_reg;
    logic [RW-1:0] hi_reg;

    logic [RW-1:0] lo_raw;
    logic [RW-1:0] floor_raw;
    logic [RW-1:0] lo_max;
    logic [RW-1:0] hi_raw;
    logic [RW-1:0] hi_clamp;

    assign lo_raw    = RW'(a_lo_reg);
    assign floor_raw = RW'(a_floor_reg);
    assign lo_max    = (lo_raw < floor_raw) ? floor_raw : lo_raw;
    assign hi_raw    = RW'(a_end_reg[31:PS]);
    assign hi_clamp  = (hi_raw > RW'(FRAME_COUNT)) ? RW'(FRAME_COUNT) : hi_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            empty_reg <= a_skip_reg || (lo_max >= hi_clamp);
            lo_reg    <= lo_max;
            hi_reg    <= hi_clamp;
        end
    end

    assign done     = done_reg;
    assign empty    = empty_reg;
    assign lo_frame = lo_reg;
    assign hi_frame = hi_reg;

endmodule

@@ src/bitmap_page_frame_allocator.sv @@
// Transactions are taken one at a time: allocate reads bitmap words up to and including the
// first with a free frame; free reads and writes back the frame's word (not when ignored);
// release waits for the region unit, then reads and rewrites each word the region touches
// (not when empty); an unknown opcode goes straight to the response. A result held by
// m_tready low adds its wait. Reset (aresetn low, synchronous) clears control state, then
// a clearing pass writes every bitmap word to all used, with s_tready low.
`include "assert_macros.svh"

module bitmap_page_frame_allocator #(
    parameter int FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BYTES  = bpfa_pkg::PAGE_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: lowest_free_address
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    // input transactions
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // address[31:0], region_base[95:32], region_length[159:96]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    // result transactions
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // frame_address[31:0]
    output logic [1:0]   m_tuser    // status[1:0]
);

    localparam int WORDS = (FRAME_COUNT + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AW1   = $clog2(WORDS + 1);
    localparam int FW    = AW + 5;
    localparam int FSW   = $clog2(FRAME_COUNT + 1);
    localparam int PS    = $clog2(PAGE_BYTES);
    localparam int LW    = 33 - PS;
    localparam int RW    = (LW > FSW) ? LW : FSW;

    // state codes
    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_ALLOC   = 3'd2;
    localparam logic [2:0] S_FREE_RD = 3'd3;
    localparam logic [2:0] S_FREE_WR = 3'd4;
    localparam logic [2:0] S_REGION  = 3'd5;
    localparam logic [2:0] S_WALK    = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] init_reg, init_next;
    logic [AW1-1:0] scan_reg, scan_next;
    logic        chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic [AW-1:0] walk_addr_reg, walk_addr_next;
    logic        walk_more_reg, walk_more_next;
    logic [31:0] free_frame_reg, free_frame_next;
    logic [FSW-1:0] frames_seen_reg, frames_seen_next;
    logic [31:0] lfa_reg;
    logic [31:0] res_addr_reg, res_addr_next;
    bpfa_pkg::status_t res_status_reg, res_status_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    bpfa_pkg::status_t m_tuser_reg, m_tuser_next;

    logic        accept;
    logic        region_go;
    logic        region_done;
    logic        region_empty;
    logic [RW-1:0] region_lo;
    logic [RW-1:0] region_hi;

    logic        wr_en;
    logic [AW-1:0] wr_addr;
    bpfa_pkg::word_t wr_data;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    bpfa_pkg::word_t rd_data;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfa_reg <= '0;
        end else if (cfg_wr_en) begin
            lfa_reg <= cfg_wr_data;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign region_go = accept && (s_tuser == bpfa_pkg::OP_RELEASE);

    // region range unit
    bpfa_region #(
        .FRAME_COUNT(FRAME_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_region (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .go                 (region_go),
        .region_base        (s_tdata[95:32]),
        .region_length      (s_tdata[159:96]),
        .lowest_free_address(lfa_reg),
        .done               (region_done),
        .empty              (region_empty),
        .lo_frame           (region_lo),
        .hi_frame           (region_hi)
    );

    // bitmap memory, one bit per frame, 1 = used
    bpfa_ram #(
        .WIDTH(bpfa_pkg::WORD_BITS),
        .DEPTH(WORDS)
    ) u_bitmap (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // frame and word positions used by the datapath
    logic [4:0]    zero_bit;
    logic [FW-1:0] alloc_frame;
    logic [FW-1:0] free_frame;
    logic [FW-1:0] lo_f;
    logic [FW-1:0] last_f;
    logic [AW-1:0] lo_w;
    logic [AW-1:0] last_w;
    bpfa_pkg::word_t clr_lo;
    bpfa_pkg::word_t clr_hi;
    logic          free_ok;

    assign zero_bit    = bpfa_pkg::lowest_zero(rd_data);
    assign alloc_frame = {chk_idx_reg, zero_bit};
    assign free_frame  = FW'(free_frame_reg);
    assign lo_f        = FW'(region_lo);
    assign last_f      = FW'(region_hi - RW'(1));
    assign lo_w        = lo_f[FW-1:5];
    assign last_w      = last_f[FW-1:5];
    assign clr_lo      = (chk_idx_reg == lo_w) ? (bpfa_pkg::ALL_ONES << lo_f[4:0])
                                               : bpfa_pkg::ALL_ONES;
    assign clr_hi      = (chk_idx_reg == last_w) ? (bpfa_pkg::ALL_ONES >> (5'd31 - last_f[4:0]))
                                                 : bpfa_pkg::ALL_ONES;
    assign free_ok     = (free_frame_reg < 32'(frames_seen_reg)) &&
                         (free_frame_reg < 32'(FRAME_COUNT));

    // sequencer: clearing pass, scans and read-modify-write of bitmap words
    always_comb begin
        state_next       = state_reg;
        init_next        = init_reg;
        scan_next        = scan_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        walk_addr_next   = walk_addr_reg;
        walk_more_next   = walk_more_reg;
        free_frame_next  = free_frame_reg;
        frames_seen_next = frames_seen_reg;
        res_addr_next    = res_addr_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        wr_en            = 1'b0;
        wr_addr          = chk_idx_reg;
        wr_data          = rd_data;
        rd_en            = 1'b0;
        rd_addr          = scan_reg[AW-1:0];

        case (state_reg)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = init_reg;
                wr_data = bpfa_pkg::ALL_ONES;
                if (init_reg == AW'(WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    init_next = init_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_addr_next   = bpfa_pkg::ALL_ONES;
                    res_status_next = bpfa_pkg::STAT_OK;
                    free_frame_next = 32'(s_tdata[31:PS]);
                    scan_next       = '0;
                    case (s_tuser)
                        bpfa_pkg::OP_ALLOC:   state_next = S_ALLOC;
                        bpfa_pkg::OP_FREE:    state_next = S_FREE_RD;
                        bpfa_pkg::OP_RELEASE: state_next = S_REGION;
                        default:              state_next = S_RESP;
                    endcase
                end
            end
            S_ALLOC: begin
                // issue one word read per cycle, check the word read in the previous cycle
                rd_en          = (scan_reg < AW1'(WORDS));
                rd_addr        = scan_reg[AW-1:0];
                chk_valid_next = rd_en;
                chk_idx_next   = rd_addr;
                if (rd_en) begin
                    scan_next = scan_reg + AW1'(1);
                end
                if (chk_valid_reg) begin
                    if (rd_data != bpfa_pkg::ALL_ONES) begin
                        wr_en          = 1'b1;
                        wr_addr        = chk_idx_reg;
                        wr_data        = rd_data | (32'd1 << zero_bit);
                        res_addr_next  = 32'(alloc_frame) << PS;
                        chk_valid_next = 1'b0;
                        state_next     = S_RESP;
                    end else if (chk_idx_reg == AW'(WORDS - 1)) begin
                        res_status_next = bpfa_pkg::STAT_NO_FRAME;
                        chk_valid_next  = 1'b0;
                        state_next      = S_RESP;
                    end
                end
            end
            S_FREE_RD: begin
                if (free_ok) begin
                    rd_en      = 1'b1;
                    rd_addr    = free_frame[FW-1:5];
                    state_next = S_FREE_WR;
                end else begin
                    res_status_next = bpfa_pkg::STAT_IGNORED;
                    state_next      = S_RESP;
                end
            end
            S_FREE_WR: begin
                wr_en      = 1'b1;
                wr_addr    = free_frame[FW-1:5];
                wr_data    = rd_data & ~(32'd1 << free_frame[4:0]);
                state_next = S_RESP;
            end
            S_REGION: begin
                if (region_done) begin
                    if (region_empty) begin
                        state_next = S_RESP;
                    end else begin
                        if (region_hi > RW'(frames_seen_reg)) begin
                            frames_seen_next = FSW'(region_hi);
                        end
                        walk_addr_next = lo_w;
                        walk_more_next = 1'b1;
                        state_next     = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // stream words lo..last, clearing the bits of the range
                rd_en          = walk_more_reg;
                rd_addr        = walk_addr_reg;
                chk_valid_next = rd_en;
                chk_idx_next   = rd_addr;
                walk_addr_next = walk_addr_reg + AW'(1);
                walk_more_next = walk_more_reg && (walk_addr_reg != last_w);
                if (chk_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_idx_reg;
                    wr_data = rd_data & ~(clr_lo & clr_hi);
                    if (chk_idx_reg == last_w) begin
                        chk_valid_next = 1'b0;
                        walk_more_next = 1'b0;
                        state_next     = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_addr_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_INIT;
            init_reg        <= '0;
            chk_valid_reg   <= 1'b0;
            walk_more_reg   <= 1'b0;
            frames_seen_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            init_reg        <= init_next;
            chk_valid_reg   <= chk_valid_next;
            walk_more_reg   <= walk_more_next;
            frames_seen_reg <= frames_seen_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        scan_reg       <= scan_next;
        chk_idx_reg    <= chk_idx_next;
        walk_addr_reg  <= walk_addr_next;
        free_frame_reg <= free_frame_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    logic rw_clash;
    logic no_frame_out;
    logic res_all_ones;
    logic in_resp;

    assign rw_clash     = wr_en && rd_en && (wr_addr == rd_addr);
    assign no_frame_out = m_tvalid && (m_tuser == bpfa_pkg::STAT_NO_FRAME);
    assign res_all_ones = (m_tdata == bpfa_pkg::ALL_ONES);
    assign in_resp      = (state_reg == S_RESP);

    `BPFA_ASSERT_ALWAYS(a_no_rw_clash, !rw_clash, "bitmap read and write hit the same word")
    `BPFA_ASSERT_ALWAYS(a_seen_in_range, frames_seen_reg <= FSW'(FRAME_COUNT), "bad frame count")
    `BPFA_ASSERT_IMPLY(a_no_frame_addr, no_frame_out, res_all_ones, "address on out of frames")
    `BPFA_ASSERT_IMPLY(a_result_origin, $rose(m_tvalid), $past(in_resp), "result outside response")

endmodule
